FILE: hw/rtl/afe_pkg.sv
// Shared types, constants and character helpers for the ASCII frame encoder.
package afe_pkg;

  // Largest payload length that still forms a frame.
  localparam logic [7:0] MaxPayload = 8'd64;

  // Number of encoded requests held between the front and the back.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Highest valid message type code (ERR).
  localparam logic [2:0] MaxMsgType = 3'd5;

  // Characters used in the frame.
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChNewline = 8'h0A;

  // Kinds of work the front hands to the back.
  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_HEADER,
    CMD_BYTE
  } cmd_kind_e;

  // Character positions of the back sequencer.
  typedef enum logic [3:0] {
    ST_AT,
    ST_LL_HI,
    ST_LL_LO,
    ST_COLON_LL,
    ST_TYPE_0,
    ST_TYPE_1,
    ST_TYPE_2,
    ST_COLON_TYPE,
    ST_BYTE,
    ST_COLON_CS,
    ST_CS_HI,
    ST_CS_LO,
    ST_NEWLINE,
    ST_REJECT
  } step_e;

  // One classified request from the front.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] msg_type;
    logic [7:0] ll;
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } afe_cmd_t;

  // Uppercase hex digit of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

  // One letter of the three-letter type name.
  function automatic logic [7:0] type_char(input logic [2:0] msg_type,
                                           input logic [1:0] idx);
    logic [23:0] text;
    logic [7:0]  ch;
    case (msg_type)
      3'd0:    text = "CMD";
      3'd1:    text = "DAT";
      3'd2:    text = "EVT";
      3'd3:    text = "STS";
      3'd4:    text = "ACK";
      3'd5:    text = "ERR";
      default: text = 24'd0;
    endcase
    case (idx)
      2'd0:    ch = text[23:16];
      2'd1:    ch = text[15:8];
      2'd2:    ch = text[7:0];
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/afe_front.sv
// Front part: accepts input items, tracks frame position and classifies each item.
module afe_front import afe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [2:0] msg_type_i,
  input  logic [7:0] body_bytes_i,
  input  logic [7:0] payload_byte_i,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output afe_cmd_t   cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       accept;

  assign accept     = push_i & ~cmd_full_i;
  assign cmd_push_o = accept;

  // Classify the item and update the frame position.
  always_comb begin
    in_frame_d      = in_frame_q;
    bytes_left_d    = bytes_left_q;
    cmd_o.kind      = CMD_BYTE;
    cmd_o.msg_type  = msg_type_i;
    cmd_o.ll        = body_bytes_i + 8'd4;
    cmd_o.data      = payload_byte_i;
    cmd_o.has_byte  = 1'b1;
    cmd_o.last      = 1'b0;
    if (!in_frame_q) begin
      if ((msg_type_i > MaxMsgType) || (body_bytes_i > MaxPayload)) begin
        cmd_o.kind = CMD_REJECT;
      end else begin
        cmd_o.kind     = CMD_HEADER;
        cmd_o.has_byte = (body_bytes_i != 8'd0);
        cmd_o.last     = (body_bytes_i <= 8'd1);
        if (accept && (body_bytes_i > 8'd1)) begin
          in_frame_d   = 1'b1;
          bytes_left_d = body_bytes_i - 8'd1;
        end
      end
    end else begin
      cmd_o.last = (bytes_left_q == 8'd1);
      if (accept) begin
        bytes_left_d = bytes_left_q - 8'd1;
        in_frame_d   = (bytes_left_q != 8'd1);
      end
    end
  end

  // Frame position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= 8'd0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

FILE: hw/rtl/afe_cmd_fifo.sv
// Short request queue between the front and the back.
module afe_cmd_fifo import afe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  afe_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output afe_cmd_t cmd_o
);

  afe_cmd_t             mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CmdCntW'(CmdDepth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Storage for queued requests.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CmdCntW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - CmdCntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/afe_back.sv
// Back part: steps through the characters of each request and fills the result register.
module afe_back import afe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  afe_cmd_t   cmd_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] frame_char_o,
  output logic       frame_end_o,
  output logic       rejected_o
);

  step_e      step_q, step_d, cur_step;
  logic       busy_q, busy_d;
  logic [7:0] xor_q, xor_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       end_q, rej_q;
  logic [7:0] ch;
  logic       ch_end, ch_rej, summed, final_step, advance;

  // Pick the current step and produce its character and successor.
  always_comb begin
    if (busy_q) begin
      cur_step = step_q;
    end else begin
      case (cmd_i.kind)
        CMD_HEADER: cur_step = ST_AT;
        CMD_BYTE:   cur_step = ST_BYTE;
        default:    cur_step = ST_REJECT;
      endcase
    end

    ch         = 8'd0;
    ch_end     = 1'b0;
    ch_rej     = 1'b0;
    summed     = 1'b0;
    final_step = 1'b0;
    step_d     = cur_step;
    case (cur_step)
      ST_AT: begin
        ch     = ChAt;
        step_d = ST_LL_HI;
      end
      ST_LL_HI: begin
        ch     = hex_char(cmd_i.ll[7:4]);
        summed = 1'b1;
        step_d = ST_LL_LO;
      end
      ST_LL_LO: begin
        ch     = hex_char(cmd_i.ll[3:0]);
        summed = 1'b1;
        step_d = ST_COLON_LL;
      end
      ST_COLON_LL: begin
        ch     = ChColon;
        summed = 1'b1;
        step_d = ST_TYPE_0;
      end
      ST_TYPE_0: begin
        ch     = type_char(cmd_i.msg_type, 2'd0);
        summed = 1'b1;
        step_d = ST_TYPE_1;
      end
      ST_TYPE_1: begin
        ch     = type_char(cmd_i.msg_type, 2'd1);
        summed = 1'b1;
        step_d = ST_TYPE_2;
      end
      ST_TYPE_2: begin
        ch     = type_char(cmd_i.msg_type, 2'd2);
        summed = 1'b1;
        step_d = ST_COLON_TYPE;
      end
      ST_COLON_TYPE: begin
        ch     = ChColon;
        summed = 1'b1;
        step_d = cmd_i.has_byte ? ST_BYTE : ST_COLON_CS;
      end
      ST_BYTE: begin
        ch         = cmd_i.data;
        summed     = 1'b1;
        step_d     = ST_COLON_CS;
        final_step = ~cmd_i.last;
      end
      ST_COLON_CS: begin
        ch     = ChColon;
        step_d = ST_CS_HI;
      end
      ST_CS_HI: begin
        ch     = hex_char(xor_q[7:4]);
        step_d = ST_CS_LO;
      end
      ST_CS_LO: begin
        ch     = hex_char(xor_q[3:0]);
        step_d = ST_NEWLINE;
      end
      ST_NEWLINE: begin
        ch         = ChNewline;
        ch_end     = 1'b1;
        final_step = 1'b1;
      end
      ST_REJECT: begin
        ch_end     = 1'b1;
        ch_rej     = 1'b1;
        final_step = 1'b1;
      end
      default: begin
        final_step = 1'b1;
      end
    endcase
  end

  // Move one character whenever a request waits and the result register is free or being emptied.
  assign advance   = cmd_valid_i & (~out_valid_q | pop_i);
  assign cmd_pop_o = advance & final_step;

  // Next values of the sequencer, the checksum and the result flag.
  always_comb begin
    busy_d      = busy_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      busy_d      = ~final_step;
      out_valid_d = 1'b1;
      if (cur_step == ST_AT) begin
        xor_d = 8'd0;
      end else if (summed) begin
        xor_d = xor_q ^ ch;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_AT;
      busy_q      <= 1'b0;
      xor_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q <= step_d;
      end
      busy_q      <= busy_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= ch;
      end_q  <= ch_end;
      rej_q  <= ch_rej;
    end
  end

  assign empty_o      = ~out_valid_q;
  assign frame_char_o = char_q;
  assign frame_end_o  = end_q;
  assign rejected_o   = rej_q;

endmodule

FILE: hw/rtl/ascii_frame_encoder_xor.sv
// Top level of the ASCII frame encoder with XOR checksum.
//
// Use: items enter through a queue-like port. A request is taken at a rising
// edge with push_i high and full_o low. The first item of a frame carries the
// message type and payload length; each item of a nonempty frame has a byte.
// Results leave one character at a time: while empty_o is low the oldest
// character is on frame_char_o, frame_end_o and rejected_o, and pop_i high
// takes it at the next rising edge.
// A taken item enters the request queue; the back sequencer then writes
// its characters into the result register: the header and any byte for a
// frame's first item, the byte alone for a later item, the trailer to close
// the frame after its last byte, and a reject marker for an invalid first
// item. It emits one character per cycle while the result register is free
// or being popped; a four-entry request queue lets the input run ahead.
// Reset clears the frame position and empties the queue and result register.
// When the receiver stalls, the result is held and the queue fills; full_o
// rises once it holds four requests.
module ascii_frame_encoder_xor import afe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [2:0] msg_type_i,
  input  logic [7:0] body_bytes_i,
  input  logic [7:0] payload_byte_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] frame_char_o,
  output logic       frame_end_o,
  output logic       rejected_o
);

  afe_cmd_t front_cmd, head_cmd;
  logic     front_push, cmd_full, cmd_valid, cmd_pop;

  afe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .msg_type_i     (msg_type_i),
    .body_bytes_i   (body_bytes_i),
    .payload_byte_i (payload_byte_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (front_push),
    .cmd_o          (front_cmd)
  );

  afe_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  afe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .frame_char_o (frame_char_o),
    .frame_end_o  (frame_end_o),
    .rejected_o   (rejected_o)
  );

  assign full_o = cmd_full;

endmodule

FILE: tb/tb_ascii_frame_encoder_xor.sv
// Self-checking testbench for the ASCII frame encoder with XOR checksum.
`timescale 1ns / 100ps

module tb_ascii_frame_encoder_xor;
  import afe_pkg::*;

  // Message type codes as they appear on msg_type_i.
  typedef enum logic [2:0] {
    MSG_CMD,
    MSG_DAT,
    MSG_EVT,
    MSG_STS,
    MSG_ACK,
    MSG_ERR,
    MSG_BAD6,
    MSG_BAD7
  } msg_type_e;

  // One input request.
  typedef struct packed {
    logic [2:0] msg_type;
    logic [7:0] body_bytes;
    logic [7:0] payload_byte;
  } enc_item_t;

  // One encoded character.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       rej;
  } enc_char_t;

  localparam int IdlePct     = 18;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 150;
  localparam int CalmFirst   = 700;
  localparam int CalmLast    = 1100;
  localparam int StallLimit  = 2000;
  localparam int RandomItems = 214;
  localparam int DrainCycles = 16;

  localparam logic [8*16-1:0] HexDigits = "0123456789ABCDEF";
  localparam logic [8*18-1:0] TypeNames = "CMDDATEVTSTSACKERR";

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push_i         = 1'b0;
  logic [2:0] msg_type_i     = 3'd0;
  logic [7:0] body_bytes_i   = 8'd0;
  logic [7:0] payload_byte_i = 8'd0;
  logic       pop_i          = 1'b0;
  logic       full_o;
  logic       empty_o;
  logic [7:0] frame_char_o;
  logic       frame_end_o;
  logic       rejected_o;

  enc_item_t pending_q[$];
  enc_char_t expected_chars_q[$];

  // Predicted encoder state.
  logic       frame_open;
  logic [7:0] bytes_remaining;
  logic [7:0] check_xor;

  int  fail_n      = 0;
  int  popped_n    = 0;
  int  cycle_n     = 0;
  int  stall_n     = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;

  wire calm     = (cycle_n >= CalmFirst) && (cycle_n < CalmLast);
  wire hold_off = (hold_left != 0);

  ascii_frame_encoder_xor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .msg_type_i     (msg_type_i),
    .body_bytes_i   (body_bytes_i),
    .payload_byte_i (payload_byte_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .frame_char_o   (frame_char_o),
    .frame_end_o    (frame_end_o),
    .rejected_o     (rejected_o)
  );

  // Free-running clock.
  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return HexDigits[8 * (15 - int'(nib)) +: 8];
  endfunction

  function automatic logic [7:0] type_letter(input logic [2:0] mt, input int idx);
    int pos;
    pos = 3 * int'(mt) + idx;
    return TypeNames[8 * (17 - pos) +: 8];
  endfunction

  task automatic add_char(input logic [7:0] ch, input logic last, input logic rej);
    expected_chars_q.push_back('{ch: ch, last: last, rej: rej});
  endtask

  // Characters covered by the checksum also update the running XOR.
  task automatic add_summed(input logic [7:0] ch);
    check_xor = check_xor ^ ch;
    add_char(ch, 1'b0, 1'b0);
  endtask

  task automatic add_trailer();
    add_char(ChColon, 1'b0, 1'b0);
    add_char(hex_ascii(check_xor[7:4]), 1'b0, 1'b0);
    add_char(hex_ascii(check_xor[3:0]), 1'b0, 1'b0);
    add_char(ChNewline, 1'b1, 1'b0);
    frame_open      = 1'b0;
    bytes_remaining = 8'd0;
    check_xor       = 8'd0;
  endtask

  // Work out the characters that one accepted request produces.
  task automatic encode_item(input enc_item_t it);
    logic [7:0] ll;
    if (!frame_open) begin
      if (it.msg_type > MaxMsgType || it.body_bytes > MaxPayload) begin
        add_char(8'h00, 1'b1, 1'b1);
        return;
      end
      ll        = 8'd4 + it.body_bytes;
      check_xor = 8'd0;
      add_char(ChAt, 1'b0, 1'b0);
      add_summed(hex_ascii(ll[7:4]));
      add_summed(hex_ascii(ll[3:0]));
      add_summed(ChColon);
      for (int i = 0; i < 3; i++) begin
        add_summed(type_letter(it.msg_type, i));
      end
      add_summed(ChColon);
      if (it.body_bytes == 8'd0) begin
        add_trailer();
        return;
      end
      add_summed(it.payload_byte);
      bytes_remaining = it.body_bytes - 8'd1;
      frame_open      = 1'b1;
      if (bytes_remaining == 8'd0) begin
        add_trailer();
      end
    end else begin
      add_summed(it.payload_byte);
      if (bytes_remaining != 8'd0) begin
        bytes_remaining = bytes_remaining - 8'd1;
      end
      if (bytes_remaining == 8'd0) begin
        add_trailer();
      end
    end
  endtask

  task automatic queue_item(input logic [2:0] mt, input logic [7:0] len,
                            input logic [7:0] data);
    pending_q.push_back('{msg_type: mt, body_bytes: len, payload_byte: data});
  endtask

  // A frame start followed by count-1 payload requests; the type and
  // length fields of later requests carry random noise.
  task automatic queue_frame(input logic [2:0] mt, input logic [7:0] len,
                             input int count);
    queue_item(mt, len, 8'($urandom_range(255)));
    for (int i = 1; i < count; i++) begin
      queue_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    end
  endtask

  task automatic build_stimulus();
    int pick;
    int len;
    int target;
    // Rejected first requests: bad types and lengths past the limit.
    queue_item(MSG_BAD6, 8'd0, 8'h00);
    queue_item(MSG_BAD7, 8'd64, 8'hFF);
    queue_item(MSG_CMD, 8'd65, 8'hA5);
    queue_item(MSG_ERR, 8'd255, 8'h5A);
    // Zero-length frames of every type; the byte is ignored.
    queue_item(MSG_CMD, 8'd0, 8'hFF);
    queue_item(MSG_DAT, 8'd0, 8'hFF);
    queue_item(MSG_EVT, 8'd0, 8'h00);
    queue_item(MSG_STS, 8'd0, 8'hFF);
    queue_item(MSG_ACK, 8'd0, 8'h80);
    queue_item(MSG_ERR, 8'd0, 8'h7F);
    // One-byte frame carrying a zero byte.
    queue_item(MSG_DAT, 8'd1, 8'h00);
    // Two-byte frame with the byte extremes.
    queue_item(MSG_EVT, 8'd2, 8'hFF);
    queue_item(MSG_CMD, 8'd0, 8'h00);
    // Fields on later requests must be ignored, even invalid ones.
    queue_item(MSG_STS, 8'd3, 8'h41);
    queue_item(MSG_BAD7, 8'd255, 8'h00);
    queue_item(MSG_BAD6, 8'd0, 8'hFF);

    target = pending_q.size() + RandomItems;
    // One frame at the largest length.
    queue_frame(3'($urandom_range(5)), MaxPayload, int'(MaxPayload));
    while (pending_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Rejected start: bad type or oversize length.
        if ($urandom_range(1) == 0) begin
          queue_item(3'($urandom_range(7, 6)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end else begin
          queue_item(3'($urandom_range(5)), 8'($urandom_range(255, 65)),
                     8'($urandom_range(255)));
        end
      end else if (pick < 13) begin
        // Broken frame: fewer requests than announced, so the next start
        // lands in the payload.
        len = $urandom_range(12, 3);
        queue_frame(3'($urandom_range(5)), 8'(len), $urandom_range(len - 1, 1));
      end else begin
        if (pick < 18) begin
          len = $urandom_range(64, 17);
        end else if (pick < 35) begin
          len = $urandom_range(16);
        end else begin
          len = $urandom_range(8, 1);
        end
        queue_frame(3'($urandom_range(5)), 8'(len), (len == 0) ? 1 : len);
      end
    end
  endtask

  // Driver: offers pending requests and records the accepted ones.
  always @(posedge clk_i) begin
    enc_item_t nxt;
    if (rst_ni) begin
      if (push_i && !full_o) begin
        encode_item({msg_type_i, body_bytes_i, payload_byte_i});
      end
      if (!(push_i && full_o)) begin
        if (pending_q.size() != 0 &&
            (calm || hold_off || $urandom_range(99) >= IdlePct)) begin
          nxt = pending_q.pop_front();
          push_i         <= 1'b1;
          msg_type_i     <= nxt.msg_type;
          body_bytes_i   <= nxt.body_bytes;
          payload_byte_i <= nxt.payload_byte;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted character against the oldest prediction.
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        popped_n <= popped_n + 1;
        if (expected_chars_q.size() == 0) begin
          $error("unexpected character %h (end %b, rejected %b)",
                 frame_char_o, frame_end_o, rejected_o);
          fail_n++;
        end else begin
          want = expected_chars_q.pop_front();
          if (frame_char_o !== want.ch) begin
            $error("frame_char: expected %h, got %h", want.ch, frame_char_o);
            fail_n++;
          end
          if (frame_end_o !== want.last) begin
            $error("frame_end: expected %b, got %b", want.last, frame_end_o);
            fail_n++;
          end
          if (rejected_o !== want.rej) begin
            $error("rejected: expected %b, got %b", want.rej, rejected_o);
            fail_n++;
          end
        end
      end
      // One long hold-off so the request queue fills and full_o rises.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop_i     <= 1'b0;
      end else if (!hold_done && popped_n >= HoldAfter) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        pop_i     <= 1'b0;
      end else begin
        pop_i <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog on cycles without any accepted request on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_n <= cycle_n + 1;
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        stall_n <= 0;
      end else if (stall_n >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_n <= stall_n + 1;
      end
    end
  end

  // Stimulus setup, reset and end of run.
  initial begin
    frame_open      = 1'b0;
    bytes_remaining = 8'd0;
    check_xor       = 8'd0;
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || push_i) @(posedge clk_i);
    while (expected_chars_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: ascii_frame_encoder_xor.f
hw/rtl/afe_pkg.sv
hw/rtl/afe_front.sv
hw/rtl/afe_cmd_fifo.sv
hw/rtl/afe_back.sv
hw/rtl/ascii_frame_encoder_xor.sv
tb/tb_ascii_frame_encoder_xor.sv
